FILE: hw/rtl/u16u8_pkg.sv
// Shared types and helpers for the UTF-16 path to UTF-8 transcoder.
// Holds the work record passed from the front end to the back end.
// No dependencies.
`default_nettype none

package u16u8_pkg;

  // Depth of the work queue between the front end and the back end.
  localparam int QDEPTH = 4;
  localparam int QAW    = $clog2(QDEPTH);

  // Number of bytes a UTF-8 sequence uses, from one to four, or none.
  localparam logic [2:0] LEN_NONE = 3'd0;
  localparam logic [2:0] LEN_ONE  = 3'd1;
  localparam logic [2:0] LEN_TWO  = 3'd2;
  localparam logic [2:0] LEN_THR  = 3'd3;
  localparam logic [2:0] LEN_FOUR = 3'd4;

  // One input item's worth of output: up to two sequences and a terminator.
  typedef struct packed {
    logic [20:0] cp_a;   // held surrogate or surrogate pair
    logic [2:0]  len_a;
    logic [15:0] cp_b;   // current unit
    logic [2:0]  len_b;
    logic        term;   // terminating zero follows
  } work_t;

  // UTF-8 length of a code point.
  function automatic logic [2:0] cp_len(input logic [20:0] cp);
    logic [2:0] len;
    if (cp <= 21'h7F) begin
      len = LEN_ONE;
    end else if (cp <= 21'h7FF) begin
      len = LEN_TWO;
    end else if (cp <= 21'hFFFF) begin
      len = LEN_THR;
    end else begin
      len = LEN_FOUR;
    end
    return len;
  endfunction

  // One byte of a sequence; rem counts bytes still to go including this one.
  function automatic logic [7:0] enc_byte(input logic [20:0] cp, input logic [2:0] len,
                                          input logic [2:0] rem);
    logic [7:0] b;
    if (rem == len) begin
      case (len)
        LEN_ONE: b = cp[7:0];
        LEN_TWO: b = {3'b110, cp[10:6]};
        LEN_THR: b = {4'b1110, cp[15:12]};
        default: b = {5'b11110, cp[20:18]};
      endcase
    end else begin
      case (rem)
        3'd1:    b = {2'b10, cp[5:0]};
        3'd2:    b = {2'b10, cp[11:6]};
        default: b = {2'b10, cp[17:12]};
      endcase
    end
    return b;
  endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/u16u8_front.sv
// Front end: accepts code units, pairs surrogates, tracks the byte budget
// and writes one work record per transaction that yields bytes.
// Depends on u16u8_pkg.
`default_nettype none

module u16u8_front #(
  parameter int PATH_BYTES = 256
) (
  input  wire                  clk,
  input  wire                  rst,
  input  wire                  s_tvalid,
  output logic                 s_tready,
  input  wire  [15:0]          s_tdata,   // [15:0] code_unit
  input  wire                  s_tlast,   // final_unit
  input  wire                  q_full,
  output logic                 push,
  output u16u8_pkg::work_t     rec
);

  localparam int CW = $clog2(PATH_BYTES);
  localparam logic [CW:0] LIMIT = (CW + 1)'(PATH_BYTES);

  logic [9:0]    held;
  logic          held_valid;
  logic [CW-1:0] count;
  logic          stopped;

  logic [9:0]    held_next;
  logic          held_valid_next;
  logic [CW-1:0] count_next;
  logic          stopped_next;

  logic          accept;
  logic          is_high;
  logic          is_low;
  logic [20:0]   cp_a;
  logic [2:0]    len_a;
  logic [15:0]   cp_b;
  logic [2:0]    len_b;
  logic          ended;
  logic          consumed;
  logic [CW:0]   cnt;
  logic [CW:0]   sum_a;
  logic [CW:0]   sum_b;

  assign s_tready = !q_full;
  assign accept   = s_tvalid && !q_full;
  assign is_high  = (s_tdata[15:10] == 6'b110110);
  assign is_low   = (s_tdata[15:10] == 6'b110111);

  // Classify the unit and decide which sequences fit in the budget.
  always_comb begin
    cp_a            = 21'd0;
    len_a           = u16u8_pkg::LEN_NONE;
    cp_b            = 16'd0;
    len_b           = u16u8_pkg::LEN_NONE;
    ended           = 1'b0;
    consumed        = 1'b0;
    cnt             = {1'b0, count};
    sum_a           = '0;
    sum_b           = '0;
    held_next       = held;
    held_valid_next = held_valid;
    count_next      = count;
    stopped_next    = stopped;

    if (stopped) begin
      if (s_tlast) begin
        stopped_next = 1'b0;
        count_next   = '0;
      end
    end else begin
      // Held high surrogate: pair it or emit it alone.
      if (held_valid) begin
        held_valid_next = 1'b0;
        held_next       = 10'd0;
        if (is_low) begin
          cp_a     = 21'h10000 + {1'b0, held, s_tdata[9:0]};
          consumed = 1'b1;
        end else begin
          cp_a = {5'd0, 6'b110110, held};
        end
        len_a = u16u8_pkg::cp_len(cp_a);
        sum_a = cnt + (CW + 1)'(len_a);
        if (sum_a >= LIMIT) begin
          ended = 1'b1;
          len_a = u16u8_pkg::LEN_NONE;
        end else begin
          cnt = sum_a;
        end
      end

      // Current unit, unless already used or the string ended.
      if (!ended && !consumed) begin
        if (s_tdata == 16'd0) begin
          ended = 1'b1;
        end else if (is_high && !s_tlast) begin
          held_next       = s_tdata[9:0];
          held_valid_next = 1'b1;
        end else begin
          cp_b  = (s_tdata == 16'h005C) ? 16'h002F : s_tdata;
          len_b = u16u8_pkg::cp_len({5'd0, cp_b});
          sum_b = cnt + (CW + 1)'(len_b);
          if (sum_b >= LIMIT) begin
            ended = 1'b1;
            len_b = u16u8_pkg::LEN_NONE;
          end else begin
            cnt = sum_b;
          end
        end
      end

      count_next = cnt[CW-1:0];
      if (s_tlast) begin
        held_next       = 10'd0;
        held_valid_next = 1'b0;
        count_next      = '0;
        stopped_next    = 1'b0;
      end else if (ended) begin
        stopped_next = 1'b1;
      end
    end
  end

  assign rec.cp_a  = cp_a;
  assign rec.len_a = len_a;
  assign rec.cp_b  = cp_b;
  assign rec.len_b = len_b;
  assign rec.term  = !stopped && (ended || s_tlast);
  assign push      = accept && ((len_a != u16u8_pkg::LEN_NONE)
                     || (len_b != u16u8_pkg::LEN_NONE) || rec.term);

  // Path state advances on every accepted transaction.
  always_ff @(posedge clk) begin
    if (rst) begin
      held       <= 10'd0;
      held_valid <= 1'b0;
      count      <= '0;
      stopped    <= 1'b0;
    end else if (accept) begin
      held       <= held_next;
      held_valid <= held_valid_next;
      count      <= count_next;
      stopped    <= stopped_next;
    end
  end

endmodule

`default_nettype wire

FILE: hw/rtl/u16u8_queue.sv
// Small work queue between the front end and the back end.
// Register array with read and write pointers. Depends on u16u8_pkg.
`default_nettype none

module u16u8_queue (
  input  wire               clk,
  input  wire               rst,
  input  wire               push,
  input  u16u8_pkg::work_t  rec_in,
  input  wire               pop,
  output u16u8_pkg::work_t  rec_out,
  output logic              full,
  output logic              nempty
);

  localparam int QD = u16u8_pkg::QDEPTH;
  localparam int AW = u16u8_pkg::QAW;

  u16u8_pkg::work_t mem [QD];
  logic [AW-1:0]    wptr;
  logic [AW-1:0]    rptr;
  logic [AW:0]      fill;

  assign full    = (fill == (AW + 1)'(QD));
  assign nempty  = (fill != '0);
  assign rec_out = mem[rptr];

  // Storage write.
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wptr] <= rec_in;
    end
  end

  // Pointers and fill level.
  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= '0;
      rptr <= '0;
      fill <= '0;
    end else begin
      if (push) begin
        wptr <= wptr + 1'b1;
      end
      if (pop) begin
        rptr <= rptr + 1'b1;
      end
      if (push && !pop) begin
        fill <= fill + 1'b1;
      end else if (pop && !push) begin
        fill <= fill - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

FILE: hw/rtl/u16u8_back.sv
// Back end: takes work records from the queue and emits UTF-8 bytes, one
// per cycle unless stalled, via an output register. Depends on u16u8_pkg.
`default_nettype none

module u16u8_back (
  input  wire               clk,
  input  wire               rst,
  input  wire               q_nempty,
  input  u16u8_pkg::work_t  rec,
  output logic              pop,
  output logic              m_tvalid,
  input  wire               m_tready,
  output logic [7:0]        m_tdata,   // [7:0] out_byte
  output logic              m_tlast,   // run_end
  output logic              m_tuser    // string_end
);

  // Record being worked on.
  logic        cur_valid;
  logic [20:0] cp_a;
  logic [2:0]  len_a;
  logic [2:0]  rem_a;
  logic [15:0] cp_b;
  logic [2:0]  len_b;
  logic [2:0]  rem_b;
  logic        term;

  logic        out_load;
  logic [7:0]  byte_next;
  logic        se_next;
  logic [2:0]  rem_a_next;
  logic [2:0]  rem_b_next;
  logic        term_next;
  logic        last;

  assign out_load = cur_valid && (!m_tvalid || m_tready);

  // Pick the next byte: sequence A, then sequence B, then the terminator.
  always_comb begin
    byte_next  = 8'd0;
    se_next    = 1'b0;
    rem_a_next = rem_a;
    rem_b_next = rem_b;
    term_next  = term;
    if (rem_a != 3'd0) begin
      byte_next  = u16u8_pkg::enc_byte(cp_a, len_a, rem_a);
      rem_a_next = rem_a - 3'd1;
    end else if (rem_b != 3'd0) begin
      byte_next  = u16u8_pkg::enc_byte({5'd0, cp_b}, len_b, rem_b);
      rem_b_next = rem_b - 3'd1;
    end else begin
      se_next   = 1'b1;
      term_next = 1'b0;
    end
  end

  assign last = (rem_a_next == 3'd0) && (rem_b_next == 3'd0) && !term_next;
  assign pop  = q_nempty && (!cur_valid || (out_load && last));

  // Working record: reload from the queue or step through the bytes.
  always_ff @(posedge clk) begin
    if (rst) begin
      cur_valid <= 1'b0;
    end else if (pop) begin
      cur_valid <= 1'b1;
    end else if (out_load) begin
      cur_valid <= !last;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      cp_a  <= rec.cp_a;
      len_a <= rec.len_a;
      rem_a <= rec.len_a;
      cp_b  <= rec.cp_b;
      len_b <= rec.len_b;
      rem_b <= rec.len_b;
      term  <= rec.term;
    end else if (out_load) begin
      rem_a <= rem_a_next;
      rem_b <= rem_b_next;
      term  <= term_next;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      m_tdata <= byte_next;
      m_tlast <= last;
      m_tuser <= se_next;
    end
  end

`ifndef SYNTH
  // The terminating zero always closes its run.
  a_term_last: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser) |-> (m_tlast && (m_tdata == 8'd0)))
    else $error("terminator is not the last zero byte of its run");

  // A record in flight always has a byte left to give.
  a_cur_nonempty: assert property (@(posedge clk) disable iff (rst)
    cur_valid |-> ((rem_a != 3'd0) || (rem_b != 3'd0) || term))
    else $error("working record holds no bytes");

  // Remaining counts never exceed the sequence lengths.
  a_rem_bound: assert property (@(posedge clk) disable iff (rst)
    cur_valid |-> ((rem_a <= len_a) && (rem_b <= len_b) && (len_a <= 3'd4)))
    else $error("remaining byte count out of range");

  // A stalled output byte is not overwritten.
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> ($stable(m_tdata) && $stable(m_tlast)))
    else $error("output byte changed under stall");
`endif

endmodule

`default_nettype wire

FILE: hw/rtl/utf16be_path_to_utf8_core.sv
// The first byte of a transaction passes through the work queue, the working record and
// the output register. Throughput: one output byte per cycle while m_tready is high;
// an input transaction yields 0 to 7 bytes (up to 4 for ordinary units); the front end
// accepts a unit every cycle while the queue has room.
// Reset: rst clears path state, the work queue and the output valid; no clearing pass.
`default_nettype none

module utf16be_path_to_utf8_core #(
  parameter int PATH_BYTES = 256
) (
  input  wire         clk,
  input  wire         rst,
  input  wire         s_tvalid,
  output logic        s_tready,
  input  wire  [15:0] s_tdata,   // [15:0] code_unit
  input  wire         s_tlast,   // final_unit
  output logic        m_tvalid,
  input  wire         m_tready,
  output logic [7:0]  m_tdata,   // [7:0] out_byte
  output logic        m_tlast,   // run_end
  output logic        m_tuser    // string_end
);

  logic             push;
  logic             pop;
  logic             q_full;
  logic             q_nempty;
  u16u8_pkg::work_t rec_in;
  u16u8_pkg::work_t rec_out;

  // Classification and path state.
  u16u8_front #(
    .PATH_BYTES(PATH_BYTES)
  ) u_front (
    .clk     (clk),
    .rst     (rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata (s_tdata),
    .s_tlast (s_tlast),
    .q_full  (q_full),
    .push    (push),
    .rec     (rec_in)
  );

  // Work queue.
  u16u8_queue u_queue (
    .clk    (clk),
    .rst    (rst),
    .push   (push),
    .rec_in (rec_in),
    .pop    (pop),
    .rec_out(rec_out),
    .full   (q_full),
    .nempty (q_nempty)
  );

  // Byte emitter.
  u16u8_back u_back (
    .clk     (clk),
    .rst     (rst),
    .q_nempty(q_nempty),
    .rec     (rec_out),
    .pop     (pop),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata),
    .m_tlast (m_tlast),
    .m_tuser (m_tuser)
  );

endmodule

`default_nettype wire

FILE: tb/utf8_path_checker.sv
// Checker for the UTF-16 path to UTF-8 transcoder: watches both stream channels,
// predicts the UTF-8 bytes of each accepted code unit and compares them in order.
// Depends on nothing but the ports of the core it watches.
`default_nettype none

module utf8_path_checker #(
  parameter int PATH_BYTES = 256
) (
  input  wire        clk,
  input  wire        rst,
  input  wire        s_tvalid,
  input  wire        s_tready,
  input  wire [15:0] s_tdata,
  input  wire        s_tlast,
  input  wire        m_tvalid,
  input  wire        m_tready,
  input  wire [7:0]  m_tdata,
  input  wire        m_tlast,
  input  wire        m_tuser,
  output int         error_count,
  output int         bytes_pending,
  output int         units_taken
);

  localparam logic [15:0] HIGH_FIRST = 16'hD800;
  localparam logic [15:0] HIGH_LAST  = 16'hDBFF;
  localparam logic [15:0] LOW_FIRST  = 16'hDC00;
  localparam logic [15:0] LOW_LAST   = 16'hDFFF;
  localparam logic [15:0] BACKSLASH  = 16'h005C;
  localparam logic [20:0] SLASH      = 21'h00002F;
  localparam logic [20:0] PLANE_ONE  = 21'h010000;

  // One output byte with its markers.
  typedef struct packed {
    logic [7:0] data;
    logic       run_end;
    logic       string_end;
  } utf8_beat_t;

  utf8_beat_t bytes_due[$];
  utf8_beat_t step_beats[$];

  // Path state of the transcoder.
  logic [9:0] held_hi;
  logic       held_ok;
  int         path_len;
  logic       halted;

  int mismatches;
  int n_units;

  function automatic void clear_path();
    held_hi  = '0;
    held_ok  = 1'b0;
    path_len = 0;
    halted   = 1'b0;
  endfunction

  function automatic void push_beat(input logic [7:0] b, input logic term);
    utf8_beat_t beat;
    beat.data       = b;
    beat.run_end    = 1'b0;
    beat.string_end = term;
    step_beats.push_back(beat);
  endfunction

  // Appends the UTF-8 form of a code point. Returns 0, and appends nothing,
  // when the sequence would leave no room for the terminating zero.
  function automatic logic encode_cp(input logic [20:0] cp);
    int n;
    if (cp <= 21'h7F) begin
      n = 1;
    end else if (cp <= 21'h7FF) begin
      n = 2;
    end else if (cp <= 21'hFFFF) begin
      n = 3;
    end else begin
      n = 4;
    end
    if (path_len + n >= PATH_BYTES) return 1'b0;
    case (n)
      1: begin
        push_beat(cp[7:0], 1'b0);
      end
      2: begin
        push_beat({3'b110, cp[10:6]}, 1'b0);
        push_beat({2'b10, cp[5:0]}, 1'b0);
      end
      3: begin
        push_beat({4'b1110, cp[15:12]}, 1'b0);
        push_beat({2'b10, cp[11:6]}, 1'b0);
        push_beat({2'b10, cp[5:0]}, 1'b0);
      end
      default: begin
        push_beat({5'b11110, cp[20:18]}, 1'b0);
        push_beat({2'b10, cp[17:12]}, 1'b0);
        push_beat({2'b10, cp[11:6]}, 1'b0);
        push_beat({2'b10, cp[5:0]}, 1'b0);
      end
    endcase
    path_len += n;
    return 1'b1;
  endfunction

  // Works out the bytes one accepted code unit causes and queues them.
  task automatic transcode_unit(input logic [15:0] u, input logic fin);
    logic       is_hi;
    logic       is_lo;
    logic       stop_now;
    logic       paired;
    utf8_beat_t tail;
    is_hi    = (u >= HIGH_FIRST) && (u <= HIGH_LAST);
    is_lo    = (u >= LOW_FIRST) && (u <= LOW_LAST);
    stop_now = 1'b0;
    paired   = 1'b0;
    step_beats.delete();

    // After the string has ended only the final unit matters.
    if (halted) begin
      if (fin) clear_path();
      return;
    end
    n_units++;

    // A held high surrogate either pairs with this unit or goes out alone.
    if (held_ok) begin
      held_ok = 1'b0;
      if (is_lo) begin
        paired = 1'b1;
        if (!encode_cp(PLANE_ONE + {1'b0, held_hi, u[9:0]})) stop_now = 1'b1;
      end else if (!encode_cp({5'b0, HIGH_FIRST[15:10], held_hi})) begin
        stop_now = 1'b1;
      end
      held_hi = '0;
    end

    // The unit itself.
    if (!stop_now && !paired) begin
      if (u == 16'h0000) begin
        stop_now = 1'b1;
      end else if (is_hi && !fin) begin
        held_hi = u[9:0];
        held_ok = 1'b1;
      end else if (!encode_cp((u == BACKSLASH) ? SLASH : {5'b0, u})) begin
        stop_now = 1'b1;
      end
    end

    // Terminating zero, then either a fresh path or the stopped state.
    if (stop_now || fin) begin
      push_beat(8'h00, 1'b1);
      if (fin) begin
        clear_path();
      end else begin
        halted = 1'b1;
      end
    end

    if (step_beats.size() != 0) begin
      tail = step_beats.pop_back();
      tail.run_end = 1'b1;
      step_beats.push_back(tail);
    end
    foreach (step_beats[i]) bytes_due.push_back(step_beats[i]);
  endtask

  // Compare the output transaction first, then predict from the input one.
  always @(posedge clk) begin : watch
    utf8_beat_t got;
    utf8_beat_t want;
    if (rst) begin
      clear_path();
      bytes_due.delete();
      mismatches = 0;
      n_units    = 0;
    end else begin
      if (m_tvalid && m_tready) begin
        got.data       = m_tdata;
        got.run_end    = m_tlast;
        got.string_end = m_tuser;
        if (bytes_due.size() == 0) begin
          if (mismatches < 10) begin
            $display("unexpected byte %h last %b end %b", got.data, got.run_end,
                     got.string_end);
          end
          mismatches++;
        end else begin
          want = bytes_due.pop_front();
          if (got !== want) begin
            if (mismatches < 10) begin
              $display("byte mismatch: expected %h last %b end %b, got %h last %b end %b",
                       want.data, want.run_end, want.string_end,
                       got.data, got.run_end, got.string_end);
            end
            mismatches++;
          end
        end
      end
      if (s_tvalid && s_tready) transcode_unit(s_tdata, s_tlast);
    end
    error_count   <= mismatches;
    bytes_pending <= bytes_due.size();
    units_taken   <= n_units;
  end

endmodule

`default_nettype wire

FILE: tb/tb_utf16be_path_to_utf8_core.sv
// Testbench top for the UTF-16 path to UTF-8 transcoder: drives code units with
// random gaps and back-pressure and gives the verdict from the checker's count.
// Depends on utf16be_path_to_utf8_core and utf8_path_checker.
`default_nettype none

module tb_utf16be_path_to_utf8_core;

  localparam int PATH_BYTES  = 256;
  localparam int QUIET_LIMIT = 3000;
  localparam int HOLD_CYCLES = 300;
  localparam int PHASE_UNITS = 10;
  localparam int WIDE_UNITS  = 105;
  localparam int DRAIN_TAIL  = 20;

  localparam logic [15:0] HIGH_FIRST = 16'hD800;
  localparam logic [15:0] HIGH_LAST  = 16'hDBFF;
  localparam logic [15:0] LOW_FIRST  = 16'hDC00;
  localparam logic [15:0] LOW_LAST   = 16'hDFFF;
  localparam logic [15:0] BACKSLASH  = 16'h005C;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [15:0] s_tdata = '0;
  logic        s_tlast = 1'b0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [7:0]  m_tdata;
  logic        m_tlast;
  logic        m_tuser;

  int   error_count;
  int   bytes_pending;
  int   units_taken;
  int   send_idle_pct = 0;
  int   stall_pct = 0;
  int   quiet_cycles = 0;
  logic recv_hold = 1'b0;
  logic long_hold_go = 1'b0;

  utf16be_path_to_utf8_core #(
    .PATH_BYTES(PATH_BYTES)
  ) i_dut (
    .clk(clk),
    .rst(rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata(s_tdata),
    .s_tlast(s_tlast),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata(m_tdata),
    .m_tlast(m_tlast),
    .m_tuser(m_tuser)
  );

  utf8_path_checker #(
    .PATH_BYTES(PATH_BYTES)
  ) i_checker (
    .clk(clk),
    .rst(rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata(s_tdata),
    .s_tlast(s_tlast),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata(m_tdata),
    .m_tlast(m_tlast),
    .m_tuser(m_tuser),
    .error_count(error_count),
    .bytes_pending(bytes_pending),
    .units_taken(units_taken)
  );

  always #5 clk = ~clk;

  // Receiver: random stalls, or a solid hold-off while one is requested.
  always @(posedge clk) begin
    m_tready <= !recv_hold && ($urandom_range(99) >= stall_pct);
  end

  // One long hold-off so the core fills up and stops taking units.
  initial begin
    wait (long_hold_go);
    @(posedge clk);
    recv_hold <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    recv_hold <= 1'b0;
  end

  // Watchdog on cycles with no transaction on either side.
  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles == QUIET_LIMIT) begin
      $display("tb_utf16be_path_to_utf8_core: errors");
      $finish;
    end
  end

  // Offers one code unit, after a random gap, and waits for its transaction.
  task automatic send_unit(input logic [15:0] u, input logic fin);
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= u;
    s_tlast  <= fin;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
  endtask

  // Stops offering and waits until every predicted byte has arrived.
  task automatic drain();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (bytes_pending != 0) @(posedge clk);
  endtask

  // A three-byte BMP unit that is not a surrogate.
  function automatic logic [15:0] bmp_unit();
    int r;
    r = $urandom_range(16'h0800, 16'hF7FF);
    if (r >= HIGH_FIRST) r += 16'h0800;
    return r[15:0];
  endfunction

  // One path segment of random units; wide paths run into the byte limit.
  task automatic send_path(input int n_units, input logic wide);
    int          k;
    int          pick;
    logic [15:0] u;
    k = 0;
    while (k < n_units) begin
      pick = $urandom_range(99);
      if (wide) pick = (pick < 80) ? 50 : (pick < 95) ? 70 : 78;
      if (pick >= 57 && pick < 75) begin
        // Surrogate pair; it may be cut short by the end of the path.
        send_unit(16'($urandom_range(HIGH_FIRST, HIGH_LAST)), k == n_units - 1);
        k++;
        if (k < n_units) begin
          send_unit(16'($urandom_range(LOW_FIRST, LOW_LAST)), k == n_units - 1);
          k++;
        end
      end else begin
        if (pick < 20) begin
          u = 16'($urandom_range(1, 127));
        end else if (pick < 30) begin
          u = BACKSLASH;
        end else if (pick < 42) begin
          u = 16'($urandom_range(16'h0080, 16'h07FF));
        end else if (pick < 57) begin
          u = bmp_unit();
        end else if (pick < 81) begin
          u = 16'($urandom_range(HIGH_FIRST, HIGH_LAST));
        end else if (pick < 87) begin
          u = 16'($urandom_range(LOW_FIRST, LOW_LAST));
        end else if (pick < 90) begin
          u = 16'h0000;
        end else begin
          u = 16'($urandom());
        end
        send_unit(u, k == n_units - 1);
        k++;
      end
    end
  endtask

  // Main sequence: reset, directed units, then four phases of random paths.
  initial begin
    int base;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Field extremes, sequences of one to three bytes, and backslash.
    send_unit(16'h0041, 1'b0);
    send_unit(16'h007F, 1'b0);
    send_unit(16'h0080, 1'b0);
    send_unit(16'h07FF, 1'b0);
    send_unit(16'h0800, 1'b0);
    send_unit(16'hFFFF, 1'b0);
    send_unit(BACKSLASH, 1'b0);
    // Lowest and highest surrogate pairs, then a lone low surrogate.
    send_unit(HIGH_FIRST, 1'b0);
    send_unit(LOW_FIRST, 1'b0);
    send_unit(HIGH_LAST, 1'b0);
    send_unit(LOW_LAST, 1'b0);
    send_unit(LOW_FIRST, 1'b0);
    // Unpaired held surrogate before a plain unit and before another high one.
    send_unit(16'hD83D, 1'b0);
    send_unit(16'h0041, 1'b0);
    send_unit(HIGH_FIRST, 1'b0);
    send_unit(HIGH_LAST, 1'b0);
    send_unit(LOW_LAST, 1'b0);
    // High surrogate as the final unit.
    send_unit(HIGH_FIRST, 1'b1);
    // Zero unit ends the string; the rest is ignored until the final unit.
    send_unit(16'h0000, 1'b0);
    send_unit(16'h1234, 1'b0);
    send_unit(16'h5678, 1'b1);
    // One-unit path, a zero that is also final, and a held unit before a zero.
    send_unit(16'h002F, 1'b1);
    send_unit(16'h0000, 1'b1);
    send_unit(16'hD801, 1'b0);
    send_unit(16'h0000, 1'b1);
    drain();

    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin
          send_idle_pct = 0;
          stall_pct    <= 0;
          long_hold_go <= 1'b1;
        end
        1: begin
          send_idle_pct = 58;
          stall_pct    <= 0;
        end
        2: begin
          send_idle_pct = 0;
          stall_pct    <= 58;
        end
        default: begin
          send_idle_pct = 25;
          stall_pct    <= 25;
        end
      endcase
      base = units_taken;
      if (ph == 0) send_path(WIDE_UNITS, 1'b1);
      while (units_taken - base < PHASE_UNITS) send_path($urandom_range(1, 10), 1'b0);
      drain();
    end

    repeat (DRAIN_TAIL) @(posedge clk);
    if (error_count == 0) begin
      $display("tb_utf16be_path_to_utf8_core: clean");
    end else begin
      $display("tb_utf16be_path_to_utf8_core: errors");
    end
    $finish;
  end

endmodule

`default_nettype wire
